// ----- rtl/core/rte_pkg.sv -----
// ----------------------------------------------------------------------------
// rte_pkg
// Types, constants and helper functions shared by the rotation matrix to
// Euler angle converter.
// ----------------------------------------------------------------------------
package rte_pkg;

  localparam int DATA_WIDTH    = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int NSTG  = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
  localparam int IW    = (NSTG > 1) ? $clog2(NSTG) : 1;
  localparam int W     = 36;
  localparam int ZW    = 34;
  localparam int AW    = 16;
  localparam int CW    = 31;
  localparam int LOW   = 17;
  localparam int PW    = W + CW + 2;

  localparam logic signed [ZW-1:0] HALF_PI   = ZW'(64'sd1073741824);
  localparam logic        [CW-1:0] INV_GAIN  = CW'(652032874);

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] n_x;
    logic signed [DATA_WIDTH-1:0] n_y;
    logic signed [DATA_WIDTH-1:0] n_z;
    logic signed [DATA_WIDTH-1:0] o_x;
    logic signed [DATA_WIDTH-1:0] o_y;
    logic signed [DATA_WIDTH-1:0] a_x;
    logic signed [DATA_WIDTH-1:0] a_y;
  } in_word_t;

  typedef struct packed {
    logic signed [AW-1:0] yaw;
    logic signed [AW-1:0] pitch;
    logic signed [AW-1:0] roll;
  } out_word_t;

  // One CORDIC lane: vector, angle, two companion pairs and a passenger value.
  typedef struct packed {
    logic                 en;
    logic signed [W-1:0]  x;
    logic signed [W-1:0]  y;
    logic signed [ZW-1:0] z;
    logic signed [W-1:0]  p0;
    logic signed [W-1:0]  q0;
    logic signed [W-1:0]  p1;
    logic signed [W-1:0]  q1;
    logic signed [W-1:0]  side;
  } cord_t;

  function automatic logic signed [W-1:0] take(input logic signed [DATA_WIDTH-1:0] v);
    logic signed [W-1:0] e;
    e = {{(W-DATA_WIDTH){v[DATA_WIDTH-1]}}, v};
    return e <<< (32 - DATA_WIDTH);
  endfunction

  function automatic logic signed [ZW-1:0] atan_val(input logic [4:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      5'd0:  r = ZW'(536870912);
      5'd1:  r = ZW'(316933406);
      5'd2:  r = ZW'(167458907);
      5'd3:  r = ZW'(85004756);
      5'd4:  r = ZW'(42667331);
      5'd5:  r = ZW'(21354465);
      5'd6:  r = ZW'(10679838);
      5'd7:  r = ZW'(5340245);
      5'd8:  r = ZW'(2670163);
      5'd9:  r = ZW'(1335087);
      5'd10: r = ZW'(667544);
      5'd11: r = ZW'(333772);
      5'd12: r = ZW'(166886);
      5'd13: r = ZW'(83443);
      5'd14: r = ZW'(41722);
      5'd15: r = ZW'(20861);
      5'd16: r = ZW'(10430);
      5'd17: r = ZW'(5215);
      5'd18: r = ZW'(2608);
      5'd19: r = ZW'(1304);
      5'd20: r = ZW'(652);
      5'd21: r = ZW'(326);
      5'd22: r = ZW'(163);
      5'd23: r = ZW'(81);
      5'd24: r = ZW'(41);
      5'd25: r = ZW'(20);
      5'd26: r = ZW'(10);
      5'd27: r = ZW'(5);
      5'd28: r = ZW'(3);
      5'd29: r = ZW'(1);
      5'd30: r = ZW'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

  // Quadrant pre-rotation: a vector in the left half-plane is turned by a
  // quarter turn, and the companion pairs follow it.
  function automatic cord_t pre_rot(input cord_t c);
    cord_t r;
    r = c;
    if (c.en && c.x < 0) begin
      if (c.y >= 0) begin
        r.x  = c.y;   r.y  = -c.x;  r.z = HALF_PI;
        r.p0 = c.q0;  r.q0 = -c.p0;
        r.p1 = c.q1;  r.q1 = -c.p1;
      end else begin
        r.x  = -c.y;  r.y  = c.x;   r.z = -HALF_PI;
        r.p0 = -c.q0; r.q0 = c.p0;
        r.p1 = -c.q1; r.q1 = c.p1;
      end
    end
    return r;
  endfunction

  // Round the angle accumulator to a 16-bit binary angle.
  function automatic logic signed [AW-1:0] to_angle(input logic signed [ZW-1:0] z);
    logic signed [ZW:0] t;
    t = {z[ZW-1], z} + (ZW+1)'(32768);
    return t[31:16];
  endfunction

endpackage

// ----- rtl/core/rte_cell.sv -----
// ----------------------------------------------------------------------------
// rte_cell
// One vectoring CORDIC micro-rotation with its own output register. The
// companion pairs are turned with the same direction bit.
// ----------------------------------------------------------------------------
module rte_cell (
  input  logic                 clk,
  input  logic                 adv,
  input  logic [rte_pkg::IW-1:0] idx,
  input  rte_pkg::cord_t       c_in,
  output rte_pkg::cord_t       c_out
);

  rte_pkg::cord_t c_r, c_nxt;
  logic signed [rte_pkg::ZW-1:0] da;
  logic up;

  always_comb begin
    c_nxt = c_in;
    up    = (c_in.y >= 0);
    da    = rte_pkg::atan_val(5'(idx));
    if (c_in.en) begin
      if (up) begin
        c_nxt.x  = c_in.x  + (c_in.y  >>> idx);
        c_nxt.y  = c_in.y  - (c_in.x  >>> idx);
        c_nxt.z  = c_in.z  + da;
        c_nxt.p0 = c_in.p0 + (c_in.q0 >>> idx);
        c_nxt.q0 = c_in.q0 - (c_in.p0 >>> idx);
        c_nxt.p1 = c_in.p1 + (c_in.q1 >>> idx);
        c_nxt.q1 = c_in.q1 - (c_in.p1 >>> idx);
      end else begin
        c_nxt.x  = c_in.x  - (c_in.y  >>> idx);
        c_nxt.y  = c_in.y  + (c_in.x  >>> idx);
        c_nxt.z  = c_in.z  - da;
        c_nxt.p0 = c_in.p0 - (c_in.q0 >>> idx);
        c_nxt.q0 = c_in.q0 + (c_in.p0 >>> idx);
        c_nxt.p1 = c_in.p1 - (c_in.q1 >>> idx);
        c_nxt.q1 = c_in.q1 + (c_in.p1 >>> idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_r <= c_nxt;
    end
  end

  assign c_out = c_r;

endmodule

// ----- rtl/core/rte_gain.sv -----
// ----------------------------------------------------------------------------
// rte_gain
// Removes the CORDIC gain from the horizontal magnitude with two partial
// products over two register stages; the other lane values ride along.
// ----------------------------------------------------------------------------
module rte_gain (
  input  logic           clk,
  input  logic           adv,
  input  rte_pkg::cord_t c_in,
  output rte_pkg::cord_t c_out
);

  logic signed [rte_pkg::W-rte_pkg::LOW-1:0]     hi;
  logic        [rte_pkg::LOW-1:0]                lo;
  logic signed [rte_pkg::W+rte_pkg::CW:0]        ph_r, ph_nxt;
  logic signed [rte_pkg::LOW+rte_pkg::CW+1:0]    pl_r, pl_nxt;
  logic signed [rte_pkg::PW-1:0]                 sum;
  rte_pkg::cord_t a_r, b_r, b_nxt;

  assign hi     = c_in.x[rte_pkg::W-1:rte_pkg::LOW];
  assign lo     = c_in.x[rte_pkg::LOW-1:0];
  assign ph_nxt = hi * $signed({1'b0, rte_pkg::INV_GAIN});
  assign pl_nxt = $signed({1'b0, lo}) * $signed({1'b0, rte_pkg::INV_GAIN});

  always_comb begin
    sum   = (rte_pkg::PW'(ph_r) <<< rte_pkg::LOW) + rte_pkg::PW'(pl_r)
          + rte_pkg::PW'(64'sd536870912);
    b_nxt = a_r;
    b_nxt.x = sum[rte_pkg::W+29:30];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ph_r <= ph_nxt;
      pl_r <= pl_nxt;
      a_r  <= c_in;
      b_r  <= b_nxt;
    end
  end

  assign c_out = b_r;

endmodule

// ----- rtl/core/rotation_matrix_to_euler.sv -----
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler
// Z-Y-X yaw, pitch and roll from seven rotation matrix entries by chained
// vectoring CORDIC cells.
// ----------------------------------------------------------------------------
// Path: pre-rotation, yaw cells, gain, pitch/roll pre-rotation, cells, output.
// Throughput: one word per cycle; the yaw chain, the gain multiplier and the
// parallel pitch and roll chains are fully pipelined.
// The whole pipeline holds only while a result word waits and is stalled.
// Reset clears the valid bits only; the datapath registers are not reset.
module rotation_matrix_to_euler (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rte_pkg::in_word_t   in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output rte_pkg::out_word_t  out_word
);

  localparam int L = 2 * rte_pkg::NSTG + 5;

  logic [L-1:0] vld_r, vld_nxt;
  logic adv;
  rte_pkg::cord_t ld, s0_r;
  rte_pkg::cord_t yc [rte_pkg::NSTG+1];
  rte_pkg::cord_t gout, pld, rld, p0_r, r0_r;
  rte_pkg::cord_t pc [rte_pkg::NSTG+1];
  rte_pkg::cord_t rc [rte_pkg::NSTG+1];
  rte_pkg::out_word_t out_r, out_nxt;

  assign adv      = !(vld_r[L-1] && out_stall);
  assign in_stall = !adv;

  always_comb begin
    ld.x    = rte_pkg::take(in_word.n_x);
    ld.y    = rte_pkg::take(in_word.n_y);
    ld.z    = '0;
    ld.p0   = rte_pkg::take(in_word.a_x);
    ld.q0   = rte_pkg::take(in_word.a_y);
    ld.p1   = rte_pkg::take(in_word.o_x);
    ld.q1   = rte_pkg::take(in_word.o_y);
    ld.side = -rte_pkg::take(in_word.n_z);
    ld.en   = (in_word.n_x != '0) || (in_word.n_y != '0);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_r <= rte_pkg::pre_rot(ld);
    end
  end

  assign yc[0] = s0_r;

  for (genvar k = 0; k < rte_pkg::NSTG; k++) begin : g_yaw
    rte_cell u_cell (
      .clk  (clk),
      .adv  (adv),
      .idx  (rte_pkg::IW'(k)),
      .c_in (yc[k]),
      .c_out(yc[k+1])
    );
  end

  rte_gain u_gain (
    .clk  (clk),
    .adv  (adv),
    .c_in (yc[rte_pkg::NSTG]),
    .c_out(gout)
  );

  // Pitch carries yaw as its passenger; roll works on the rotated pairs.
  always_comb begin
    pld      = '0;
    pld.x    = gout.x;
    pld.y    = gout.side;
    pld.side = rte_pkg::W'(gout.z);
    pld.en   = (gout.x != '0) || (gout.side != '0);
    rld      = '0;
    rld.x    = gout.q1;
    rld.y    = -gout.q0;
    rld.en   = (gout.q1 != '0) || (gout.q0 != '0);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p0_r <= rte_pkg::pre_rot(pld);
      r0_r <= rte_pkg::pre_rot(rld);
    end
  end

  assign pc[0] = p0_r;
  assign rc[0] = r0_r;

  for (genvar k = 0; k < rte_pkg::NSTG; k++) begin : g_pr
    rte_cell u_pcell (
      .clk  (clk),
      .adv  (adv),
      .idx  (rte_pkg::IW'(k)),
      .c_in (pc[k]),
      .c_out(pc[k+1])
    );
    rte_cell u_rcell (
      .clk  (clk),
      .adv  (adv),
      .idx  (rte_pkg::IW'(k)),
      .c_in (rc[k]),
      .c_out(rc[k+1])
    );
  end

  always_comb begin
    out_nxt.yaw   = rte_pkg::to_angle(rte_pkg::ZW'(pc[rte_pkg::NSTG].side));
    out_nxt.pitch = rte_pkg::to_angle(pc[rte_pkg::NSTG].z);
    out_nxt.roll  = rte_pkg::to_angle(rc[rte_pkg::NSTG].z);
  end

  assign vld_nxt = {vld_r[L-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = vld_r[L-1];
  assign out_word  = out_r;

endmodule

// ----- rtl/core/rte_checker.sv -----
// ----------------------------------------------------------------------------
// rte_checker
// Port-level checks for the rotation matrix to Euler angle converter.
// ----------------------------------------------------------------------------
module rte_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input rte_pkg::in_word_t  in_word,
  input logic               out_valid,
  input logic               out_stall,
  input rte_pkg::out_word_t out_word
);

  // A stalled result word stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // The input side only stalls behind a stalled result word.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // Nothing comes out straight after reset.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid after reset");

  // An accepted word carries no unknown bits.
  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> !$isunknown(in_word))
    else $error("accepted word has unknown bits");

endmodule

bind rotation_matrix_to_euler rte_checker u_rte_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_word  (in_word),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_word (out_word)
);
